[rtl/cesp_pkg.sv]
// Shared types and constants of the colour e-paper subpixel packer.
// No dependencies; imported by every module of the block.
package cesp_pkg;

  localparam int MAX_ROW_BYTES = 256;
  localparam int MAX_ROWS      = 4096;
  localparam int ROW_BYTES_W   = 9;
  localparam int ROW_W         = 12;
  localparam int IDX_W         = 8;
  localparam int CHAN_W        = 8;
  localparam int SUM_W         = 10;
  localparam int IN_DATA_W     = 72;
  localparam int OUT_DATA_W    = 40;
  localparam int Q_DEPTH       = 8;
  localparam int Q_ADDR_W      = $clog2(Q_DEPTH);
  localparam int Q_CNT_W       = Q_ADDR_W + 1;

  localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST = ROW_BYTES_W'(200);

  // quantiser thresholds on the three-pixel sum (average times 3)
  localparam logic [SUM_W-1:0] SUM_BOTH   = SUM_W'(64 * 3);
  localparam logic [SUM_W-1:0] SUM_PLANE1 = SUM_W'(128 * 3);
  localparam logic [SUM_W-1:0] SUM_PLANE0 = SUM_W'(192 * 3);

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef logic [2:0] mask_t;

  typedef struct packed {
    logic [2:0]       p0;
    logic [2:0]       p1;
    logic             eor;
    logic [ROW_W-1:0] row;
  } cls_t;

  typedef struct packed {
    logic [7:0]       p0;
    logic [7:0]       p1;
    logic [IDX_W-1:0] idx;
    logic [ROW_W-1:0] row;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       a;
    res_t       b;
  } push_t;

  // subpixel bit of a channel for a given row phase
  function automatic mask_t chan_mask(input logic [1:0] chan, input logic [1:0] phase);
    mask_t m;
    m = 3'd0;
    case (chan)
      CH_RED: begin
        case (phase)
          2'd1:    m = 3'd1;
          2'd2:    m = 3'd4;
          default: m = 3'd2;
        endcase
      end
      CH_GREEN: begin
        case (phase)
          2'd1:    m = 3'd4;
          2'd2:    m = 3'd2;
          default: m = 3'd1;
        endcase
      end
      default: begin
        case (phase)
          2'd1:    m = 3'd2;
          2'd2:    m = 3'd1;
          default: m = 3'd4;
        endcase
      end
    endcase
    return m;
  endfunction

endpackage

[rtl/cesp_classify.sv]
// Front end: accepts pixel groups, averages and quantises each channel,
// tracks row phase and row number. Depends on cesp_pkg.
module cesp_classify (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [cesp_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tlast,
  output logic                            cls_valid,
  input  logic                            cls_ready,
  output cesp_pkg::cls_t                  cls
);
  import cesp_pkg::*;

  logic [1:0]       row_phase;
  logic [ROW_W-1:0] row_count;
  logic [SUM_W-1:0] sum [3];
  logic [2:0]       p0_next;
  logic [2:0]       p1_next;
  logic             take;

  assign s_tready = !cls_valid || cls_ready;
  assign take     = s_tvalid && s_tready;

  always_comb begin
    p0_next = 3'd0;
    p1_next = 3'd0;
    for (int c = 0; c < 3; c++) begin
      sum[c] = SUM_W'(s_tdata[c*CHAN_W +: CHAN_W])
             + SUM_W'(s_tdata[(c+3)*CHAN_W +: CHAN_W])
             + SUM_W'(s_tdata[(c+6)*CHAN_W +: CHAN_W]);
      if (sum[c] < SUM_BOTH) begin
        p0_next = p0_next | chan_mask(2'(c), row_phase);
        p1_next = p1_next | chan_mask(2'(c), row_phase);
      end else if (sum[c] < SUM_PLANE1) begin
        p1_next = p1_next | chan_mask(2'(c), row_phase);
      end else if (sum[c] < SUM_PLANE0) begin
        p0_next = p0_next | chan_mask(2'(c), row_phase);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
      row_phase <= 2'd0;
      row_count <= '0;
    end else begin
      if (take) begin
        cls_valid <= 1'b1;
      end else if (cls_ready) begin
        cls_valid <= 1'b0;
      end
      if (take && s_tlast) begin
        if (row_count == ROW_W'(MAX_ROWS - 1)) begin
          row_count <= '0;
          row_phase <= 2'd0;
        end else begin
          row_count <= row_count + 1'b1;
          row_phase <= (row_phase == 2'd2) ? 2'd0 : row_phase + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cls.p0  <= p0_next;
      cls.p1  <= p1_next;
      cls.eor <= s_tlast;
      cls.row <= row_count;
    end
  end

endmodule

[rtl/cesp_pack.sv]
// Back end: shifts 3-bit patterns into the two plane bytes, counts bytes
// per row, drops bytes past the limit and flushes at end of row. Depends on cesp_pkg.
module cesp_pack (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cls_valid,
  output logic                              cls_ready,
  input  cesp_pkg::cls_t                    cls,
  input  logic [cesp_pkg::ROW_BYTES_W-1:0]  row_bytes,
  input  logic                              room,
  output cesp_pkg::push_t                   push
);
  import cesp_pkg::*;

  logic [7:0]             acc0;
  logic [7:0]             acc1;
  logic [2:0]             bits_filled;
  logic [ROW_BYTES_W-1:0] byte_count;

  logic                   fire;
  logic [3:0]             sh;
  logic [15:0]            w0;
  logic [15:0]            w1;
  logic [3:0]             total;
  logic                   full;
  logic [7:0]             acc0_mid;
  logic [7:0]             acc1_mid;
  logic [2:0]             bf_mid;
  logic [ROW_BYTES_W-1:0] bc_mid;
  logic [ROW_BYTES_W-1:0] lim;
  logic                   keep_a;
  logic                   keep_b;
  res_t                   res_a;
  res_t                   res_b;

  assign cls_ready = room;
  assign fire      = cls_valid && room;

  always_comb begin
    lim      = (row_bytes > ROW_BYTES_W'(MAX_ROW_BYTES)) ? ROW_BYTES_W'(MAX_ROW_BYTES)
                                                         : row_bytes;
    sh       = 4'd13 - {1'b0, bits_filled};
    w0       = {acc0, 8'h00} | (16'(cls.p0) << sh);
    w1       = {acc1, 8'h00} | (16'(cls.p1) << sh);
    total    = {1'b0, bits_filled} + 4'd3;
    full     = total[3];
    acc0_mid = full ? w0[7:0] : w0[15:8];
    acc1_mid = full ? w1[7:0] : w1[15:8];
    bf_mid   = total[2:0];
    bc_mid   = (full && byte_count != '1) ? byte_count + 1'b1 : byte_count;
    keep_a   = full && (byte_count < lim);
    keep_b   = cls.eor && (bf_mid != 3'd0) && (bc_mid < lim);

    res_a.p0   = w0[15:8];
    res_a.p1   = w1[15:8];
    res_a.idx  = byte_count[IDX_W-1:0];
    res_a.row  = cls.row;
    res_a.last = !keep_b;
    res_b.p0   = acc0_mid;
    res_b.p1   = acc1_mid;
    res_b.idx  = bc_mid[IDX_W-1:0];
    res_b.row  = cls.row;
    res_b.last = 1'b1;

    push.n = 2'd0;
    push.a = res_a;
    push.b = res_b;
    if (fire) begin
      if (keep_a) begin
        push.n = keep_b ? 2'd2 : 2'd1;
      end else if (keep_b) begin
        push.n = 2'd1;
        push.a = res_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc0        <= 8'h00;
      acc1        <= 8'h00;
      bits_filled <= 3'd0;
      byte_count  <= '0;
    end else if (fire) begin
      if (cls.eor) begin
        acc0        <= 8'h00;
        acc1        <= 8'h00;
        bits_filled <= 3'd0;
        byte_count  <= '0;
      end else begin
        acc0        <= acc0_mid;
        acc1        <= acc1_mid;
        bits_filled <= bf_mid;
        byte_count  <= bc_mid;
      end
    end
  end

endmodule

[rtl/cesp_queue.sv]
// Result queue: takes up to two items a cycle from the packer while it has room, hands one
// a cycle to the output stream while that stream is ready. Depends on cesp_pkg.
module cesp_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  cesp_pkg::push_t                push,
  output logic                           room,
  output logic [cesp_pkg::Q_CNT_W-1:0]   level,
  output logic                           head_valid,
  input  logic                           head_ready,
  output cesp_pkg::res_t                 head
);
  import cesp_pkg::*;

  res_t                mem [Q_DEPTH];
  logic [Q_ADDR_W-1:0] wptr;
  logic [Q_ADDR_W-1:0] rptr;
  logic [Q_CNT_W-1:0]  count;
  logic                pop;

  assign level      = count;
  assign room       = count <= Q_CNT_W'(Q_DEPTH - 2);
  assign head_valid = count != '0;
  assign head       = mem[rptr];
  assign pop        = head_valid && head_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + Q_ADDR_W'(push.n);
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + Q_CNT_W'(push.n) - Q_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wptr] <= push.a;
    end
    if (push.n == 2'd2) begin
      mem[wptr + 1'b1] <= push.b;
    end
  end

endmodule

[rtl/color_epaper_subpixel_packer.sv]
// Top level of the colour e-paper subpixel packer: row length register,
// classify front end, packer and result queue. Depends on cesp_pkg and all cesp_* modules.
//
//   channel  | direction | tdata / data                         | tuser | tlast
//   s_*      | in        | red_a..blue_c, 9 x 8 bits            | -     | end_of_row
//   m_*      | out       | plane0, plane1, byte_index, row_number | -   | last_of_run
//   cfg_*    | in        | row_bytes, 9 bits                    | -     | -
//
// One pixel group per clock while the queue has room; groups pass the classify register and the queue on the way to m.
// The classify register and an 8-item result queue sit between the ports, so
// input is taken while results wait; input stalls only once the queue holds 7.
// Up to two results per group, one result leaves per clock while m_tready is high.
// Synchronous active-high reset; row_bytes returns to 200.
module color_epaper_subpixel_packer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [cesp_pkg::IN_DATA_W-1:0]    s_tdata,  // red_a,green_a,blue_a,red_b,..,blue_c
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [cesp_pkg::OUT_DATA_W-1:0]   m_tdata,  // plane0,plane1,byte_index,row_number,pad
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cesp_pkg::ROW_BYTES_W-1:0]  cfg_data
);
  import cesp_pkg::*;

  logic [ROW_BYTES_W-1:0] row_bytes;
  logic                   cls_valid;
  logic                   cls_ready;
  cls_t                   cls;
  push_t                  push;
  logic                   room;
  logic [Q_CNT_W-1:0]     level;
  res_t                   head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes <= ROW_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      row_bytes <= cfg_data;
    end
  end

  cesp_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cls_valid (cls_valid),
    .cls_ready (cls_ready),
    .cls       (cls)
  );

  cesp_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .cls_valid (cls_valid),
    .cls_ready (cls_ready),
    .cls       (cls),
    .row_bytes (row_bytes),
    .room      (room),
    .push      (push)
  );

  cesp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .level      (level),
    .head_valid (m_tvalid),
    .head_ready (m_tready),
    .head       (head)
  );

  assign m_tdata = {4'b0000, head.row, head.idx, head.p1, head.p0};
  assign m_tlast = head.last;

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> (cls_valid && room))
    else $error("push into queue without room");

  a_level: assert property (@(posedge clk) disable iff (rst)
    level <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue overflow");

  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd2) |-> (!push.a.last && push.b.last))
    else $error("last_of_run misplaced on a pair");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd1) |-> push.a.last)
    else $error("single result lacks last_of_run");

endmodule
